// ===== design/xck_pkg.sv =====
// Shared types, constants and functions for the XChaCha20 keystream XOR block.
package xck_pkg;

    localparam int CFG_COUNT   = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = 6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NONCE2 = 3'd6;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] state_t;

    // Core job kinds
    typedef enum logic [1:0]
    {
        CORE_IDLE,
        CORE_SUBKEY,
        CORE_BLOCK
    } core_st_t;

    // Request from the top level to the core
    typedef struct packed
    {
        logic        start;
        logic        hchacha;
        logic [63:0] counter;
    } core_req_t;

    // Core status back to the top level
    typedef struct packed
    {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic word_t rotl(input word_t v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // One column or diagonal step: four quarter rounds in parallel
    function automatic state_t quarter4(input state_t s, input logic diag);
        state_t r;
        int a, b, c, d;
        r = s;
        for (int i = 0; i < 4; i++)
        begin
            a = i;
            b = diag ? 4 + ((i + 1) % 4) : 4 + i;
            c = diag ? 8 + ((i + 2) % 4) : 8 + i;
            d = diag ? 12 + ((i + 3) % 4) : 12 + i;
            r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 16);
            r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 12);
            r[a] = r[a] + r[b]; r[d] = rotl(r[d] ^ r[a], 8);
            r[c] = r[c] + r[d]; r[b] = rotl(r[b] ^ r[c], 7);
        end
        return r;
    endfunction

endpackage

// ===== design/xchacha20_keystream_xor.sv =====
// Top level of the XChaCha20 keystream XOR block.
// Usage:
//  - Write the key and nonce through cfg_we/cfg_index/cfg_data while idle;
//    any write to index 0..6 restarts the stream at block 0 and forces a new subkey.
//    A block or subkey still being built at that time is discarded.
//  - Input words (data_byte, last_byte) arrive on in_valid/in_stall; each
//    returns one output word (out_byte, last_out) on out_valid/out_stall.
//  - Throughput: one byte per cycle inside a 64-byte block while out_stall is low.
//    The round engine runs one round a cycle. The next block is built into
//    the second RAM bank while the current one is consumed, so a steady
//    stream keeps one byte per cycle.
//  - The first byte after set-up waits for subkey derivation and then for
//    the first block; otherwise a byte passes the keystream RAM read and
//    the output register.
//  - Reset clears the counter, position and bank state; no RAM clearing pass.
//  - When out_stall is high the output word holds; in_stall rises while no subkey
//    or ready block is present, once the skid word is full, or while the read stage
//    and output word are both occupied and out_stall is high.
module xchacha20_keystream_xor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_out
);

    logic [63:0] cfg_reg [xck_pkg::CFG_COUNT];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < xck_pkg::CFG_COUNT; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we && (cfg_index < 3'(xck_pkg::CFG_COUNT)))
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    logic cfg_hit;
    assign cfg_hit = cfg_we && (cfg_index <= xck_pkg::REG_NONCE2);

    // Stream control
    logic        sk_ok_reg, sk_ok_next;
    logic        sk_run_reg, sk_run_next;
    logic [1:0]  ready_reg, ready_next;     // per-bank block-ready flags
    logic [1:0]  fill_reg, fill_next;       // per-bank build in progress
    logic        rbank_reg, rbank_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] ctr_reg, ctr_next;
    logic        wbank_reg, wbank_next;
    logic        drop_reg, drop_next;       // core job made stale by a set-up write

    xck_pkg::core_req_t  req;
    xck_pkg::core_stat_t stat;
    logic        ks_we;
    logic [3:0]  ks_waddr;
    logic [31:0] ks_wdata;

    // Output path: RAM read stage, then output register with a skid word
    logic       p_vld_reg, p_vld_next;
    logic       p_last_reg;
    logic [7:0] p_data_reg;
    logic       o_vld_reg, o_vld_next;
    logic [7:0] o_byte_reg, o_byte_next;
    logic       o_last_reg, o_last_next;
    logic       k_vld_reg, k_vld_next;
    logic [7:0] k_byte_reg, k_byte_next;
    logic       k_last_reg, k_last_next;
    logic [7:0] ks_byte;
    logic       take;

    assign in_stall = !sk_ok_reg || !ready_reg[rbank_reg] || k_vld_reg
                      || (p_vld_reg && o_vld_reg && out_stall);
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        sk_ok_next  = sk_ok_reg;
        sk_run_next = sk_run_reg;
        ready_next  = ready_reg;
        fill_next   = fill_reg;
        rbank_next  = rbank_reg;
        pos_next    = pos_reg;
        ctr_next    = ctr_reg;
        wbank_next  = wbank_reg;
        drop_next   = drop_reg;
        req.start   = 1'b0;
        req.hchacha = 1'b0;
        req.counter = ctr_reg;

        if (stat.done)
        begin
            if (drop_reg)
            begin
                drop_next = 1'b0;
            end
            else if (sk_run_reg)
            begin
                sk_ok_next  = 1'b1;
                sk_run_next = 1'b0;
            end
            else
            begin
                ready_next[wbank_reg] = 1'b1;
                fill_next[wbank_reg]  = 1'b0;
            end
        end

        if (take)
        begin
            pos_next = pos_reg + 6'd1;
            if (pos_reg == 6'(xck_pkg::BLOCK_BYTES - 1))
            begin
                ready_next[rbank_reg] = 1'b0;
                rbank_next            = !rbank_reg;
            end
        end

        // Launch subkey derivation, then block builds into a free bank
        if (!stat.busy && !stat.done)
        begin
            if (!sk_ok_reg)
            begin
                if (!sk_run_reg && in_valid)
                begin
                    req.start   = 1'b1;
                    req.hchacha = 1'b1;
                    sk_run_next = 1'b1;
                end
            end
            else if (!ready_reg[wbank_reg] && !fill_reg[wbank_reg])
            begin
                req.start             = 1'b1;
                fill_next[wbank_reg]  = 1'b1;
                ctr_next              = ctr_reg + 64'd1;
            end
            else if (ready_reg[wbank_reg] && !ready_reg[!wbank_reg]
                     && !fill_reg[!wbank_reg])
            begin
                wbank_next = !wbank_reg;
            end
        end

        if (cfg_hit)
        begin
            sk_ok_next  = 1'b0;
            sk_run_next = 1'b0;
            ready_next  = '0;
            fill_next   = '0;
            rbank_next  = 1'b0;
            wbank_next  = 1'b0;
            pos_next    = '0;
            ctr_next    = '0;
            drop_next   = stat.busy || req.start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sk_ok_reg  <= 1'b0;
            sk_run_reg <= 1'b0;
            ready_reg  <= '0;
            fill_reg   <= '0;
            rbank_reg  <= 1'b0;
            pos_reg    <= '0;
            ctr_reg    <= '0;
            wbank_reg  <= 1'b0;
            drop_reg   <= 1'b0;
            p_vld_reg  <= 1'b0;
            o_vld_reg  <= 1'b0;
            k_vld_reg  <= 1'b0;
        end
        else
        begin
            sk_ok_reg  <= sk_ok_next;
            sk_run_reg <= sk_run_next;
            ready_reg  <= ready_next;
            fill_reg   <= fill_next;
            rbank_reg  <= rbank_next;
            pos_reg    <= pos_next;
            ctr_reg    <= ctr_next;
            wbank_reg  <= wbank_next;
            drop_reg   <= drop_next;
            p_vld_reg  <= p_vld_next;
            o_vld_reg  <= o_vld_next;
            k_vld_reg  <= k_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p_data_reg <= data_byte;
            p_last_reg <= last_byte;
        end
        o_byte_reg <= o_byte_next;
        o_last_reg <= o_last_next;
        k_byte_reg <= k_byte_next;
        k_last_reg <= k_last_next;
    end

    // Output register with skid word; the read stage always drains
    always_comb
    begin
        p_vld_next  = take;
        o_vld_next  = o_vld_reg;
        o_byte_next = o_byte_reg;
        o_last_next = o_last_reg;
        k_vld_next  = k_vld_reg;
        k_byte_next = k_byte_reg;
        k_last_next = k_last_reg;
        if (o_vld_reg && !out_stall)
        begin
            o_vld_next = 1'b0;
            if (k_vld_reg)
            begin
                o_vld_next  = 1'b1;
                o_byte_next = k_byte_reg;
                o_last_next = k_last_reg;
                k_vld_next  = 1'b0;
            end
        end
        if (p_vld_reg)
        begin
            if (!o_vld_next)
            begin
                o_vld_next  = 1'b1;
                o_byte_next = p_data_reg ^ ks_byte;
                o_last_next = p_last_reg;
            end
            else
            begin
                k_vld_next  = 1'b1;
                k_byte_next = p_data_reg ^ ks_byte;
                k_last_next = p_last_reg;
            end
        end
    end

    assign out_valid = o_vld_reg;
    assign out_byte  = o_byte_reg;
    assign last_out  = o_last_reg;

    xck_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .key      ({cfg_reg[3], cfg_reg[2], cfg_reg[1], cfg_reg[0]}),
        .hnonce   ({cfg_reg[5], cfg_reg[4]}),
        .nonce2   (cfg_reg[6]),
        .stat     (stat),
        .ks_we    (ks_we),
        .ks_waddr (ks_waddr),
        .ks_wdata (ks_wdata)
    );

    xck_buf u_buf
    (
        .clk   (clk),
        .we    (ks_we),
        .wbank (wbank_reg),
        .waddr (ks_waddr),
        .wdata (ks_wdata),
        .rbank (rbank_reg),
        .raddr (pos_reg),
        .rdata (ks_byte)
    );

    // A byte is only taken from a bank whose block is complete
    a_ready_bank: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ready_reg[rbank_reg])
        else $error("byte taken from a bank with no block");

    // The core never writes a bank while that bank holds a ready block
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ks_we |-> !ready_reg[wbank_reg])
        else $error("keystream write into a ready bank");

    // Skid word is only occupied while the output word is held
    a_skid: assert property (@(posedge clk) disable iff (!rst_n)
        k_vld_reg |-> o_vld_reg)
        else $error("skid word valid without output word");

endmodule

// ===== design/xck_core.sv =====
// ChaCha round engine: one column or diagonal round per cycle, subkey held in a RAM.
module xck_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  xck_pkg::core_req_t req,
    input  logic [255:0]       key,
    input  logic [127:0]       hnonce,
    input  logic [63:0]        nonce2,
    output xck_pkg::core_stat_t stat,
    // keystream word write port towards the byte buffer
    output logic               ks_we,
    output logic [3:0]         ks_waddr,
    output logic [31:0]        ks_wdata
);

    xck_pkg::core_st_t st_reg, st_next;
    xck_pkg::state_t   s_reg, s_next;
    xck_pkg::state_t   init_reg, init_next;
    logic [4:0]        rnd_reg, rnd_next;
    logic [3:0]        wr_reg, wr_next;
    logic              out_reg, out_next;
    logic              done_reg, done_next;

    // Subkey RAM: eight words, written after derivation, read during set-up
    logic [31:0] sk_mem [8];
    logic        sk_we;
    logic [2:0]  sk_addr;
    logic [31:0] sk_wdata;
    logic [31:0] sk_rdata_reg;
    logic [3:0]  ld_reg, ld_next;
    logic        ld_act_reg, ld_act_next;

    always_ff @(posedge clk)
    begin
        if (sk_we)
        begin
            sk_mem[sk_addr] <= sk_wdata;
        end
        sk_rdata_reg <= sk_mem[sk_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= xck_pkg::CORE_IDLE;
            rnd_reg    <= '0;
            wr_reg     <= '0;
            out_reg    <= 1'b0;
            done_reg   <= 1'b0;
            ld_reg     <= '0;
            ld_act_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            rnd_reg    <= rnd_next;
            wr_reg     <= wr_next;
            out_reg    <= out_next;
            done_reg   <= done_next;
            ld_reg     <= ld_next;
            ld_act_reg <= ld_act_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        init_reg <= init_next;
    end

    // Sequencer: load, 20 rounds, then write back results
    always_comb
    begin
        st_next     = st_reg;
        s_next      = s_reg;
        init_next   = init_reg;
        rnd_next    = rnd_reg;
        wr_next     = wr_reg;
        out_next    = out_reg;
        done_next   = 1'b0;
        ld_next     = ld_reg;
        ld_act_next = ld_act_reg;
        sk_we       = 1'b0;
        sk_addr     = ld_reg[2:0];
        sk_wdata    = s_reg[0];
        ks_we       = 1'b0;
        ks_waddr    = wr_reg;
        ks_wdata    = s_reg[wr_reg] + init_reg[wr_reg];
        case (st_reg)
            xck_pkg::CORE_IDLE:
            begin
                if (req.start)
                begin
                    init_next[0] = xck_pkg::SIGMA0;
                    init_next[1] = xck_pkg::SIGMA1;
                    init_next[2] = xck_pkg::SIGMA2;
                    init_next[3] = xck_pkg::SIGMA3;
                    for (int i = 0; i < 8; i++)
                    begin
                        init_next[4 + i] = key[32*i +: 32];
                    end
                    if (req.hchacha)
                    begin
                        for (int i = 0; i < 4; i++)
                        begin
                            init_next[12 + i] = hnonce[32*i +: 32];
                        end
                        s_next      = init_next;
                        ld_act_next = 1'b0;
                    end
                    else
                    begin
                        init_next[12] = req.counter[31:0];
                        init_next[13] = req.counter[63:32];
                        init_next[14] = nonce2[31:0];
                        init_next[15] = nonce2[63:32];
                        ld_act_next   = 1'b1;
                        ld_next       = '0;
                        sk_addr       = 3'd0;
                    end
                    rnd_next = '0;
                    out_next = 1'b0;
                    wr_next  = '0;
                    st_next  = req.hchacha ? xck_pkg::CORE_SUBKEY : xck_pkg::CORE_BLOCK;
                end
            end
            xck_pkg::CORE_SUBKEY:
            begin
                if (!out_reg)
                begin
                    s_next   = xck_pkg::quarter4(s_reg, rnd_reg[0]);
                    rnd_next = rnd_reg + 5'd1;
                    if (rnd_reg == 5'd19)
                    begin
                        out_next = 1'b1;
                        wr_next  = '0;
                    end
                end
                else
                begin
                    // subkey words are state words 0..3 and 12..15
                    sk_we    = 1'b1;
                    sk_addr  = wr_reg[2:0];
                    sk_wdata = s_reg[wr_reg[2] ? {2'b11, wr_reg[1:0]} : {2'b00, wr_reg[1:0]}];
                    wr_next  = wr_reg + 4'd1;
                    if (wr_reg == 4'd7)
                    begin
                        st_next   = xck_pkg::CORE_IDLE;
                        done_next = 1'b1;
                    end
                end
            end
            xck_pkg::CORE_BLOCK:
            begin
                if (ld_act_reg)
                begin
                    // read subkey word ld; it comes back registered in the next cycle, seen there as word ld-1
                    sk_addr = ld_reg[2:0];
                    if (ld_reg != 4'd0)
                    begin
                        init_next[3 + ld_reg] = sk_rdata_reg;
                    end
                    ld_next = ld_reg + 4'd1;
                    if (ld_reg == 4'd8)
                    begin
                        ld_act_next = 1'b0;
                        s_next      = init_next;
                    end
                end
                else if (!out_reg)
                begin
                    s_next   = xck_pkg::quarter4(s_reg, rnd_reg[0]);
                    rnd_next = rnd_reg + 5'd1;
                    if (rnd_reg == 5'd19)
                    begin
                        out_next = 1'b1;
                        wr_next  = '0;
                    end
                end
                else
                begin
                    ks_we   = 1'b1;
                    wr_next = wr_reg + 4'd1;
                    if (wr_reg == 4'd15)
                    begin
                        st_next   = xck_pkg::CORE_IDLE;
                        done_next = 1'b1;
                    end
                end
            end
            default:
            begin
                st_next = xck_pkg::CORE_IDLE;
            end
        endcase
    end

    assign stat.busy = (st_reg != xck_pkg::CORE_IDLE);
    assign stat.done = done_reg;

endmodule

// ===== design/xck_buf.sv =====
// Double-buffered keystream RAM: word writes from the core, byte reads for the data path.
module xck_buf
(
    input  logic        clk,
    input  logic        we,
    input  logic        wbank,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic        rbank,
    input  logic [5:0]  raddr,
    output logic [7:0]  rdata
);

    logic [31:0] mem [32];
    logic [31:0] rword_reg;
    logic [1:0]  rsel_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[{wbank, waddr}] <= wdata;
        end
        rword_reg <= mem[{rbank, raddr[5:2]}];
        rsel_reg  <= raddr[1:0];
    end

    assign rdata = rword_reg[8*rsel_reg +: 8];

endmodule

// ===== tb/tb_xchacha20_keystream_xor.sv =====
// Testbench for the XChaCha20 keystream XOR block: self-checking, with its own cipher model.
module tb_xchacha20_keystream_xor;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic        last_out;

    xchacha20_keystream_xor dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_byte(out_byte),
        .last_out(last_out)
    );

    // Model state
    logic [63:0] key_nonce_regs [xck_pkg::CFG_COUNT];
    logic [31:0] subkey [8];
    logic        subkey_ready;
    logic [7:0]  ks_bytes [xck_pkg::BLOCK_BYTES];
    int          ks_pos;
    logic [63:0] ks_counter;

    logic [8:0]  pending_words [$];
    int          error_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix_step(inout logic [31:0] s [16], input int a, input int b,
                                     input int c, input int d);
        s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 16);
        s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 12);
        s[a] = s[a] + s[b]; s[d] = rot_left(s[d] ^ s[a], 8);
        s[c] = s[c] + s[d]; s[b] = rot_left(s[b] ^ s[c], 7);
    endfunction

    function automatic void chacha_rounds(inout logic [31:0] s [16]);
        for (int i = 0; i < 10; i++)
        begin
            mix_step(s, 0, 4, 8, 12);
            mix_step(s, 1, 5, 9, 13);
            mix_step(s, 2, 6, 10, 14);
            mix_step(s, 3, 7, 11, 15);
            mix_step(s, 0, 5, 10, 15);
            mix_step(s, 1, 6, 11, 12);
            mix_step(s, 2, 7, 8, 13);
            mix_step(s, 3, 4, 9, 14);
        end
    endfunction

    // Cipher prediction for one byte
    function automatic logic [8:0] predict_cipher_byte(input logic [7:0] b, input logic lst);
        logic [31:0] s [16];
        logic [31:0] init [16];
        logic [31:0] w;
        logic [31:0] sig [4];
        sig[0] = xck_pkg::SIGMA0; sig[1] = xck_pkg::SIGMA1;
        sig[2] = xck_pkg::SIGMA2; sig[3] = xck_pkg::SIGMA3;
        if (!subkey_ready)
        begin
            for (int i = 0; i < 4; i++)
            begin
                s[i] = sig[i];
                s[4 + 2 * i] = key_nonce_regs[i][31:0];
                s[5 + 2 * i] = key_nonce_regs[i][63:32];
            end
            s[12] = key_nonce_regs[xck_pkg::REG_NONCE0][31:0];
            s[13] = key_nonce_regs[xck_pkg::REG_NONCE0][63:32];
            s[14] = key_nonce_regs[xck_pkg::REG_NONCE1][31:0];
            s[15] = key_nonce_regs[xck_pkg::REG_NONCE1][63:32];
            chacha_rounds(s);
            for (int i = 0; i < 4; i++)
            begin
                subkey[i] = s[i];
                subkey[4 + i] = s[12 + i];
            end
            subkey_ready = 1'b1;
        end
        if (ks_pos >= xck_pkg::BLOCK_BYTES)
        begin
            for (int i = 0; i < 4; i++)
                init[i] = sig[i];
            for (int i = 0; i < 8; i++)
                init[4 + i] = subkey[i];
            init[12] = ks_counter[31:0];
            init[13] = ks_counter[63:32];
            init[14] = key_nonce_regs[xck_pkg::REG_NONCE2][31:0];
            init[15] = key_nonce_regs[xck_pkg::REG_NONCE2][63:32];
            s = init;
            chacha_rounds(s);
            for (int i = 0; i < 16; i++)
            begin
                w = s[i] + init[i];
                for (int j = 0; j < 4; j++)
                    ks_bytes[4 * i + j] = w[8 * j +: 8];
            end
            ks_pos = 0;
            ks_counter = ks_counter + 64'd1;
        end
        w[7:0] = b ^ ks_bytes[ks_pos];
        ks_pos = ks_pos + 1;
        return {lst, w[7:0]};
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Output checker and stall generation
    always @(posedge clk)
    begin
        logic [8:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_words.size() == 0)
                report_mismatch("unexpected word", {last_out, out_byte}, 0);
            else
            begin
                want = pending_words.pop_front();
                if (out_byte !== want[7:0])
                    report_mismatch("out_byte", out_byte, want[7:0]);
                if (last_out !== want[8])
                    report_mismatch("last_out", last_out, want[8]);
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_words.push_back(predict_cipher_byte(b, lst));
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (120) @(negedge clk);
    endtask

    // Idle-only register write, model kept in step
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx < xck_pkg::CFG_COUNT)
        begin
            key_nonce_regs[idx] = val;
            ks_counter   = 64'd0;
            ks_pos       = xck_pkg::BLOCK_BYTES;
            subkey_ready = 1'b0;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed_extremes();
        write_reg(xck_pkg::REG_KEY0, '1);
        write_reg(xck_pkg::REG_KEY3, 64'h8000_0000_0000_0001);
        write_reg(xck_pkg::REG_NONCE0, '1);
        write_reg(xck_pkg::REG_NONCE2, 64'h0123_4567_89ab_cdef);
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b1);
        send_word(8'h55, 1'b0);
        send_word(8'haa, 1'b1);
        for (int i = 0; i < 8; i++)
            send_word(8'h01 << i, i[0]);
        drain_results();
        // Out-of-range index leaves the stream running
        write_reg(3'd7, rand64());
        for (int i = 0; i < 8; i++)
            send_word(8'($urandom_range(255)), 1'b0);
        drain_results();
    endtask

    task automatic test_all_registers();
        for (int r = 0; r < xck_pkg::CFG_COUNT; r++)
            write_reg(r[2:0], (r % 2) ? 64'd0 : rand64());
        for (int i = 0; i < 70; i++)
            send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
        drain_results();
    endtask

    // Random buffers under one idling and stall setting, with key or nonce changes between
    task automatic test_random_stream(input int idle_pct, input int stall_pct, input int n);
        int sent;
        sent = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n)
        begin
            write_reg(3'($urandom_range(6)), rand64());
            for (int i = 0; i < 150 && sent < n; i++)
            begin
                send_word(8'($urandom_range(255)), ($urandom_range(15) == 0));
                sent++;
            end
            drain_results();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        in_valid = 1'b0; data_byte = '0; last_byte = 1'b0;
        out_stall = 1'b0;
        send_idle_pct = 0; recv_stall_pct = 0;
        error_count = 0; cycle_count = 0;
        for (int i = 0; i < xck_pkg::CFG_COUNT; i++)
            key_nonce_regs[i] = '0;
        subkey_ready = 1'b0; ks_pos = xck_pkg::BLOCK_BYTES; ks_counter = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_all_registers();
        test_random_stream(0, 0, 300);
        test_random_stream(68, 0, 300);
        test_random_stream(0, 68, 300);
        test_random_stream(21, 21, 300);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
design/xck_pkg.sv
design/xck_core.sv
design/xck_buf.sv
design/xchacha20_keystream_xor.sv
tb/tb_xchacha20_keystream_xor.sv
